// ===== rtl/overwrite_ring_buffer_lifo_core_assert.svh =====
// Assertion macros shared by the ring buffer RTL.
// Both sample on clk and are switched off while rst_n is low.
`ifndef OVERWRITE_RING_BUFFER_LIFO_CORE_ASSERT_SVH
`define OVERWRITE_RING_BUFFER_LIFO_CORE_ASSERT_SVH

// Check that cond holds in the same cycle as trig.
`define ORB_ASSERT_NOW(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("ring buffer check failed");

// Check that cond holds in the cycle after trig.
`define ORB_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("ring buffer check failed");

`endif

// ===== rtl/orb_lifo_pkg.sv =====
package orb_lifo_pkg;

  localparam int FUNC_W = 3;
  localparam int OCC_W  = 7;
  localparam int CFG_W  = 32;
  localparam int ADDR_W = 3;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FN_PUSH       = 3'd0;
  localparam func_t FN_PEEK       = 3'd1;
  localparam func_t FN_POP        = 3'd2;
  localparam func_t FN_ITER_START = 3'd3;
  localparam func_t FN_ITER_NEXT  = 3'd4;

  // Register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // Per-item info that travels alongside the memory read
  typedef struct packed {
    logic             hit;
    logic [OCC_W-1:0] occ;
  } item_meta_t;

endpackage

// ===== rtl/overwrite_ring_buffer_lifo_core.sv =====
// Pipeline: an accepted item passes the registered memory read (read stage), then the
// output register, which holds the result while out_tready is low.
// Throughput: one item per cycle while out_tready is high; the single read/write port
// of the slot memory serves one slot per item, and pointer state updates at accept.
// Reset (synchronous, rst_n low): head, count and iterator cleared, capacity set to
// min(64, DEPTH), pipeline emptied. Slot memory is not cleared and has no clearing pass.
`include "overwrite_ring_buffer_lifo_core_assert.svh"

module overwrite_ring_buffer_lifo_core #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: func[2:0], data_in[DATA_WIDTH+2:3], zero padding
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((orb_lifo_pkg::FUNC_W+DATA_WIDTH+7)/8)*8-1:0] in_tdata,
  // out_tdata: data_out[DATA_WIDTH-1:0], data_valid, occupancy[6:0], zero padding
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [((DATA_WIDTH+1+orb_lifo_pkg::OCC_W+7)/8)*8-1:0] out_tdata,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [orb_lifo_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [orb_lifo_pkg::CFG_W-1:0]   cfg_pwdata,
  output logic [orb_lifo_pkg::CFG_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);
  import orb_lifo_pkg::*;

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CW      = (CNT_W > OCC_W) ? CNT_W : OCC_W;
  localparam int OUT_W   = ((DATA_WIDTH + 1 + OCC_W + 7) / 8) * 8;
  localparam int CAP_RST = (DEPTH < 64) ? DEPTH : 64;

  // Slot memory: one synchronous port pair, read data registered.
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_r;
  logic                  mem_we;
  logic                  mem_re;
  logic [AW-1:0]         mem_addr;

  // Pointer state
  logic [AW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [AW-1:0]    iter_idx_r, iter_idx_nxt;
  logic [CNT_W-1:0] iter_rem_r, iter_rem_nxt;
  logic [CNT_W-1:0] cap_r;

  // Read stage and output register
  logic            s1_valid_r;
  item_meta_t      s1_meta_r, s1_meta_nxt;
  logic            out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  item_meta_t      out_meta_r;

  logic            out_free;
  logic            in_acc;
  logic            cfg_we;
  func_t           func;
  logic [DATA_WIDTH-1:0] data_in;
  logic [AW-1:0]   cap_last;
  logic [CNT_W-1:0] head_inc;
  logic [CW-1:0]   cfg_ext;
  logic [CW-1:0]   occ_ext;
  logic [CNT_W-1:0] cap_clamped;

  assign func    = in_tdata[FUNC_W-1:0];
  assign data_in = in_tdata[FUNC_W+DATA_WIDTH-1:FUNC_W];

  // Handshakes: a finished item may sit in the output register while the next
  // one is read; the read stage moves whenever the output register frees up.
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign cap_last = AW'(cap_r - CNT_W'(1));
  assign head_inc = CNT_W'(head_r) + CNT_W'(1);

  // Walk one slot toward older data, wrapping at the capacity
  function automatic logic [AW-1:0] step_back(input logic [AW-1:0] idx,
                                              input logic [AW-1:0] last);
    step_back = (idx == '0) ? last : idx - AW'(1);
  endfunction

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    iter_idx_nxt = iter_idx_r;
    iter_rem_nxt = iter_rem_r;
    mem_we       = 1'b0;
    mem_addr     = head_r;
    s1_meta_nxt.hit = 1'b0;
    case (func)
      FN_PUSH: begin
        mem_we   = 1'b1;
        mem_addr = head_r;
        // Full store: the write overwrites the oldest word, read it out as evicted
        if (count_r >= cap_r) begin
          s1_meta_nxt.hit = 1'b1;
          count_nxt       = cap_r;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
        head_nxt = (head_inc >= cap_r) ? '0 : AW'(head_inc);
      end
      FN_PEEK: begin
        mem_addr = step_back(head_r, cap_last);
        s1_meta_nxt.hit = (count_r != '0);
      end
      FN_POP: begin
        mem_addr = step_back(head_r, cap_last);
        if (count_r != '0) begin
          s1_meta_nxt.hit = 1'b1;
          count_nxt       = count_r - CNT_W'(1);
          head_nxt        = mem_addr;
        end
      end
      FN_ITER_START: begin
        iter_idx_nxt = head_r;
        iter_rem_nxt = count_r;
      end
      FN_ITER_NEXT: begin
        mem_addr = step_back(iter_idx_r, cap_last);
        if (iter_rem_r != '0) begin
          s1_meta_nxt.hit = 1'b1;
          iter_rem_nxt    = iter_rem_r - CNT_W'(1);
          iter_idx_nxt    = mem_addr;
        end
      end
      default: begin
      end
    endcase
    occ_ext         = CW'(count_nxt);
    s1_meta_nxt.occ = occ_ext[OCC_W-1:0];
  end

  assign mem_re = in_acc;

  // Read-before-write: an evicting push returns the word it replaces
  always_ff @(posedge clk) begin
    if (in_acc && mem_we) begin
      mem[mem_addr] <= data_in;
    end
    if (mem_re) begin
      rd_r <= mem[mem_addr];
    end
  end

  // Configuration: clamp the low 7 bits into 1..DEPTH
  assign cfg_we  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                   (cfg_paddr[2] == REG_CAPACITY);
  assign cfg_ext = CW'(cfg_pwdata[OCC_W-1:0]);

  always_comb begin
    if (cfg_ext == '0) begin
      cap_clamped = CNT_W'(1);
    end else if (cfg_ext > CW'(DEPTH)) begin
      cap_clamped = CNT_W'(DEPTH);
    end else begin
      cap_clamped = CNT_W'(cfg_ext);
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? CFG_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r      <= CNT_W'(CAP_RST);
      head_r     <= '0;
      count_r    <= '0;
      iter_idx_r <= '0;
      iter_rem_r <= '0;
    end else if (cfg_we) begin
      // Empty the buffer and end any iteration
      cap_r      <= cap_clamped;
      head_r     <= '0;
      count_r    <= '0;
      iter_idx_r <= '0;
      iter_rem_r <= '0;
    end else if (in_acc) begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      iter_idx_r <= iter_idx_nxt;
      iter_rem_r <= iter_rem_nxt;
    end
  end

  // Read stage and output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_valid_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: hold while stalled, zero the data of an item that carries none
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_meta_r <= s1_meta_nxt;
    end
    if (s1_valid_r && out_free) begin
      out_meta_r <= s1_meta_r;
      out_data_r <= s1_meta_r.hit ? rd_r : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_meta_r.occ, out_meta_r.hit, out_data_r});

  `ORB_ASSERT_NOW(a_count_in_cap, 1'b1, count_r <= cap_r)
  `ORB_ASSERT_NOW(a_head_in_cap, 1'b1, CNT_W'(head_r) < cap_r)
  `ORB_ASSERT_NOW(a_empty_zero, out_valid_r && !out_meta_r.hit, out_data_r == '0)
  `ORB_ASSERT_NEXT(a_stall_holds, s1_valid_r && !out_free, s1_valid_r && out_valid_r)

endmodule

// ===== tb/sv/tb_overwrite_ring_buffer_lifo_core.sv =====
`timescale 1ns / 100ps

module tb_overwrite_ring_buffer_lifo_core;
  import orb_lifo_pkg::*;

  localparam int SLOTS  = 64;
  localparam int DATA_W = 32;
  localparam int IN_W   = ((FUNC_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_W  = ((DATA_W + 1 + OCC_W + 7) / 8) * 8;

  // Byte address of the capacity register (register index sits in paddr[2]).
  localparam logic [ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

  // First of the unused function codes; the codes above it up to 7 are unused too.
  localparam func_t FN_NOP_FIRST = 3'd5;

  // Cycles from input accept to result, plus margin, waited before a register write.
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              valid;
    logic [OCC_W-1:0]  occ;
  } lifo_result_t;

  // Shadow copy of the ring buffer: tracks pointers and slot contents, and holds
  // the results that accepted items must still produce, oldest first.
  class ring_shadow;
    logic [DATA_W-1:0] slot_mem [SLOTS];
    int unsigned head, count, iter_pos, iter_left, cap;
    lifo_result_t pending_results[$];
    int unsigned mismatches, checked, evictions, iter_reads, empty_reads;

    function new();
      foreach (slot_mem[i]) slot_mem[i] = '0;
      cap = SLOTS;
      mismatches = 0;
      checked = 0;
      evictions = 0;
      iter_reads = 0;
      empty_reads = 0;
      clear_pointers();
    endfunction

    function void clear_pointers();
      head = 0;
      count = 0;
      iter_pos = 0;
      iter_left = 0;
    endfunction

    // Saturate the low 7 bits into 1..SLOTS and empty the buffer.
    function void apply_capacity(logic [CFG_W-1:0] value);
      int unsigned c;
      c = value[6:0];
      if (c < 1) c = 1;
      if (c > SLOTS) c = SLOTS;
      cap = c;
      clear_pointers();
    endfunction

    function int unsigned step_back(int unsigned i);
      if (i == 0 || i > cap) return cap - 1;
      return i - 1;
    endfunction

    function void take_item(func_t f, logic [DATA_W-1:0] w);
      lifo_result_t r;
      r = '0;
      case (f)
        FN_PUSH: begin
          if (head >= cap) head = 0;
          if (count >= cap) begin
            r.word = slot_mem[head];
            r.valid = 1'b1;
            count = cap;
            evictions++;
          end else begin
            count++;
          end
          slot_mem[head] = w;
          head = (head + 1 >= cap) ? 0 : head + 1;
        end
        FN_PEEK: begin
          if (count != 0) begin
            r.word = slot_mem[step_back(head)];
            r.valid = 1'b1;
          end else begin
            empty_reads++;
          end
        end
        FN_POP: begin
          if (count != 0) begin
            count--;
            head = step_back(head);
            r.word = slot_mem[head];
            r.valid = 1'b1;
          end else begin
            empty_reads++;
          end
        end
        FN_ITER_START: begin
          iter_pos = head;
          iter_left = count;
        end
        FN_ITER_NEXT: begin
          if (iter_left != 0) begin
            iter_left--;
            iter_pos = step_back(iter_pos);
            r.word = slot_mem[iter_pos];
            r.valid = 1'b1;
            iter_reads++;
          end
        end
        default: ;
      endcase
      r.occ = count[OCC_W-1:0];
      pending_results.push_back(r);
    endfunction

    task flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatches++;
    endtask

    task check_item(logic [OUT_W-1:0] t);
      lifo_result_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", t[DATA_W-1:0], '0);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (t[DATA_W-1:0] !== want.word) flag_mismatch("data_out", t[DATA_W-1:0], want.word);
      if (t[DATA_W] !== want.valid)
        flag_mismatch("data_valid", DATA_W'(t[DATA_W]), DATA_W'(want.valid));
      if (t[DATA_W+OCC_W:DATA_W+1] !== want.occ)
        flag_mismatch("occupancy", DATA_W'(t[DATA_W+OCC_W:DATA_W+1]), DATA_W'(want.occ));
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // func[2:0], data_in[34:3], zero padding
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // data_out[31:0], data_valid[32], occupancy[39:33]
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [CFG_W-1:0] cfg_pwdata;
  logic [CFG_W-1:0] cfg_prdata;
  logic             cfg_pready;

  ring_shadow  shadow;
  bit          steady;        // when set, neither side idles
  int unsigned items_sent;
  int unsigned cap_writes;

  overwrite_ring_buffer_lifo_core #(
    .DEPTH      (SLOTS),
    .DATA_WIDTH (DATA_W)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // Offer one item, hold it until accepted, then record its expected result.
  // Drive on the falling edge; sample the handshake on the rising edge.
  task automatic send_item(func_t f, logic [DATA_W-1:0] w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W - FUNC_W - DATA_W){1'b0}}, w, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    shadow.take_item(f, w);
    items_sent++;
    // Every so often switch between idling and back-to-back stretches.
    if (items_sent % 40 == 0) steady = ($urandom_range(0, 3) == 0);
  endtask

  // Drop valid and hold until every recorded result has come back.
  task automatic drain_results(int extra);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (shadow.pending_results.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access until pready.
  task automatic write_capacity(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CAP_ADDR;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    shadow.apply_capacity(value);
    cap_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] rand_word();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // Iterator walk: start a snapshot, then step through it and a little past
  // the end, with the odd push mixed in so the walk sees live overwrites.
  task automatic iterator_walk();
    int unsigned steps;
    send_item(FN_ITER_START, rand_word());
    steps = shadow.count + $urandom_range(0, 2);
    repeat (steps) begin
      if ($urandom_range(0, 9) == 0) send_item(FN_PUSH, rand_word());
      else send_item(FN_ITER_NEXT, rand_word());
    end
  endtask

  // One random phase: mostly pushes, pops and walks; the rest is peeks,
  // stray iterator steps and unused codes.
  task automatic random_phase(int unsigned n_items, int unsigned push_pct);
    int unsigned start, r;
    start = items_sent;
    while (items_sent - start < n_items) begin
      // Pause at most once mid-phase until the block has returned everything.
      if (items_sent - start >= n_items / 2 && items_sent - start < n_items / 2 + 1)
        drain_results(0);
      if ($urandom_range(0, 99) < 8) begin
        iterator_walk();
      end else begin
        r = $urandom_range(0, 99);
        if (r < push_pct) send_item(FN_PUSH, rand_word());
        else if (r < push_pct + 10) send_item(FN_PEEK, rand_word());
        else if (r < push_pct + 35) send_item(FN_POP, rand_word());
        else if (r < push_pct + 42) send_item(FN_ITER_NEXT, rand_word());
        else send_item(FN_NOP_FIRST + func_t'($urandom_range(0, 2)), rand_word());
      end
    end
  endtask

  // Result side: stall a random number of cycles per item, then take it
  // and check it against the oldest recorded expectation.
  initial begin
    int stall;
    forever begin
      stall = steady ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && rst_n)) @(posedge clk);
      shadow.check_item(out_tdata);
    end
  end

  initial begin
    logic [CFG_W-1:0] cap_value;
    int unsigned      n_items, push_pct;

    shadow      = new();
    steady      = 1'b0;
    items_sent  = 0;
    cap_writes  = 0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;

    // Hold reset, then release on a falling edge.
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, at the reset capacity: reads on an empty buffer, an exhausted
    // iterator, unused codes, then a short fill and read back.
    send_item(FN_PEEK, '1);
    send_item(FN_POP, '1);
    send_item(FN_ITER_START, '0);
    send_item(FN_ITER_NEXT, '0);
    send_item(FN_NOP_FIRST, '1);
    send_item(FN_NOP_FIRST + func_t'(1), '0);
    send_item(FN_NOP_FIRST + func_t'(2), '1);
    send_item(FN_PUSH, '0);
    send_item(FN_PUSH, '1);
    send_item(FN_PEEK, '0);
    send_item(FN_ITER_START, '0);
    send_item(FN_ITER_NEXT, '0);
    send_item(FN_ITER_NEXT, '0);
    send_item(FN_POP, '0);
    send_item(FN_POP, '0);

    // Directed, capacity 3: eviction on a full buffer, and a push that lands
    // under a running iterator so the walk reads the overwritten slot.
    drain_results(SETTLE_CYCLES);
    write_capacity(32'd3);
    send_item(FN_PUSH, 32'hAAAA_AAAA);
    send_item(FN_PUSH, 32'h5555_5555);
    send_item(FN_PUSH, 32'h0000_0000);
    send_item(FN_PUSH, 32'hFFFF_FFFF);
    send_item(FN_ITER_START, '0);
    send_item(FN_PUSH, 32'h1234_5678);
    repeat (4) send_item(FN_ITER_NEXT, '0);
    send_item(FN_POP, '0);

    // Random phases over a spread of capacity settings: zero (taken as one),
    // an out-of-range value (saturates to full depth), small rings, the full
    // depth with heavier pushing, and a word with junk in the upper bits.
    for (int ph = 0; ph < 7; ph++) begin
      n_items  = 110;
      push_pct = 40;
      case (ph)
        0: cap_value = 32'd0;
        1: cap_value = 32'd127;
        2: cap_value = 32'd2;
        3: begin
          cap_value = 32'd64;
          n_items   = 250;
          push_pct  = 55;
        end
        4: cap_value = $urandom;
        5: cap_value = 32'd1;
        default: cap_value = 32'd5;
      endcase
      drain_results(SETTLE_CYCLES);
      write_capacity(cap_value);
      random_phase(n_items, push_pct);
    end

    // Let the last results out, then a few quiet cycles.
    drain_results(SETTLE_CYCLES * 4);

    $display("covered %0d items over %0d capacity writes, %0d results checked",
             items_sent, cap_writes, shadow.checked);
    $display("including %0d evictions, %0d iterator reads, %0d reads of an empty buffer",
             shadow.evictions, shadow.iter_reads, shadow.empty_reads);
    if (shadow.mismatches == 0 && shadow.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/orb_lifo_pkg.sv
rtl/overwrite_ring_buffer_lifo_core.sv
tb/sv/tb_overwrite_ring_buffer_lifo_core.sv
